### design/sint_pkg.sv
package sint_pkg;

   // Field widths
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   // Derived arithmetic widths
   localparam int DIFF_W     = COORD_BITS + 1;           // endpoint differences
   localparam int PROD_W     = 2 * DIFF_W;               // difference products
   localparam int SUM_W      = PROD_W + 1;               // den, numA, numB
   localparam int MAG_W      = SUM_W - 1;                // magnitudes of those
   localparam int REM_W      = MAG_W + 1;                // divider partial remainder
   localparam int QUO_W      = FRAC_BITS + 1;            // param_a, Q1.FRAC
   localparam int DIV_STAGES = QUO_W;                    // one quotient bit per stage
   localparam int CROSS_W    = COORD_BITS + FRAC_BITS;   // cross_x, cross_y
   localparam int SCALE_W    = DIFF_W + QUO_W + 1;       // d * t products

   // Stream widths
   localparam int IN_FIELDS     = 8;
   localparam int REQ_DATA_W    = ((IN_FIELDS * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_PAYLOAD_W = QUO_W + 2 * CROSS_W;
   localparam int RSP_DATA_W    = ((RSP_PAYLOAD_W + 7) / 8) * 8;

   // Segment A data carried alongside the division
   typedef struct packed {
      logic                         valid;
      logic                         hit;
      logic signed [COORD_BITS-1:0] sxa;
      logic signed [COORD_BITS-1:0] sya;
      logic signed [DIFF_W-1:0]     dxa;
      logic signed [DIFF_W-1:0]     dya;
   } sint_carry_type;

   // Front end to divider
   typedef struct packed {
      sint_carry_type     carry;
      logic [MAG_W-1:0]   num_mag;
      logic [MAG_W-1:0]   den_mag;
   } sint_work_type;

   // Divider to point stage
   typedef struct packed {
      sint_carry_type     carry;
      logic [QUO_W-1:0]   quo;
   } sint_param_type;

   // Point stage to output register
   typedef struct packed {
      logic               valid;
      logic               hit;
      logic [QUO_W-1:0]   param;
      logic [CROSS_W-1:0] cross_x;
      logic [CROSS_W-1:0] cross_y;
   } sint_result_type;

endpackage

### design/sint_front.sv
module sint_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [sint_pkg::REQ_DATA_W-1:0] in_data,
   output sint_pkg::sint_work_type         work_out
);
   import sint_pkg::*;

   logic signed [COORD_BITS-1:0] sxa, sya, exa, eya, sxb, syb, exb, eyb;

   // Unpack the word, first field lowest
   assign sxa = in_data[0*COORD_BITS +: COORD_BITS];
   assign sya = in_data[1*COORD_BITS +: COORD_BITS];
   assign exa = in_data[2*COORD_BITS +: COORD_BITS];
   assign eya = in_data[3*COORD_BITS +: COORD_BITS];
   assign sxb = in_data[4*COORD_BITS +: COORD_BITS];
   assign syb = in_data[5*COORD_BITS +: COORD_BITS];
   assign exb = in_data[6*COORD_BITS +: COORD_BITS];
   assign eyb = in_data[7*COORD_BITS +: COORD_BITS];

   // Stage 1: differences
   logic                         s1_valid_ff;
   logic signed [COORD_BITS-1:0] s1_sxa_ff, s1_sya_ff;
   logic signed [DIFF_W-1:0]     s1_dxa_ff, s1_dya_ff, s1_dxb_ff, s1_dyb_ff;
   logic signed [DIFF_W-1:0]     s1_ex_ff, s1_ey_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sxa_ff <= sxa;
         s1_sya_ff <= sya;
         s1_dxa_ff <= DIFF_W'(exa) - DIFF_W'(sxa);
         s1_dya_ff <= DIFF_W'(eya) - DIFF_W'(sya);
         s1_dxb_ff <= DIFF_W'(exb) - DIFF_W'(sxb);
         s1_dyb_ff <= DIFF_W'(eyb) - DIFF_W'(syb);
         s1_ex_ff  <= DIFF_W'(sxa) - DIFF_W'(sxb);
         s1_ey_ff  <= DIFF_W'(syb) - DIFF_W'(sya);
      end
   end

   // Stage 2: cross products
   logic                         s2_valid_ff;
   logic signed [COORD_BITS-1:0] s2_sxa_ff, s2_sya_ff;
   logic signed [DIFF_W-1:0]     s2_dxa_ff, s2_dya_ff;
   logic signed [PROD_W-1:0]     s2_dyadxb_ff, s2_dxadyb_ff;
   logic signed [PROD_W-1:0]     s2_exdyb_ff, s2_eydxb_ff, s2_exdya_ff, s2_eydxa_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_sxa_ff    <= s1_sxa_ff;
         s2_sya_ff    <= s1_sya_ff;
         s2_dxa_ff    <= s1_dxa_ff;
         s2_dya_ff    <= s1_dya_ff;
         s2_dyadxb_ff <= PROD_W'(s1_dya_ff) * PROD_W'(s1_dxb_ff);
         s2_dxadyb_ff <= PROD_W'(s1_dxa_ff) * PROD_W'(s1_dyb_ff);
         s2_exdyb_ff  <= PROD_W'(s1_ex_ff) * PROD_W'(s1_dyb_ff);
         s2_eydxb_ff  <= PROD_W'(s1_ey_ff) * PROD_W'(s1_dxb_ff);
         s2_exdya_ff  <= PROD_W'(s1_ex_ff) * PROD_W'(s1_dya_ff);
         s2_eydxa_ff  <= PROD_W'(s1_ey_ff) * PROD_W'(s1_dxa_ff);
      end
   end

   // Stage 3: determinant and numerators
   logic                         s3_valid_ff;
   logic signed [COORD_BITS-1:0] s3_sxa_ff, s3_sya_ff;
   logic signed [DIFF_W-1:0]     s3_dxa_ff, s3_dya_ff;
   logic signed [SUM_W-1:0]      s3_den_ff, s3_numa_ff, s3_numb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_sxa_ff  <= s2_sxa_ff;
         s3_sya_ff  <= s2_sya_ff;
         s3_dxa_ff  <= s2_dxa_ff;
         s3_dya_ff  <= s2_dya_ff;
         s3_den_ff  <= SUM_W'(s2_dyadxb_ff) - SUM_W'(s2_dxadyb_ff);
         s3_numa_ff <= SUM_W'(s2_exdyb_ff) + SUM_W'(s2_eydxb_ff);
         s3_numb_ff <= SUM_W'(s2_exdya_ff) + SUM_W'(s2_eydxa_ff);
      end
   end

   // Stage 4: bounds test on signs, magnitudes for the divider
   logic                    den_pos, ratio_a, ratio_b, hit;
   logic signed [SUM_W-1:0] numa_abs, den_abs;
   sint_work_type           work_in, work_ff;

   always_comb begin
      den_pos = s3_den_ff > 0;
      if (den_pos) begin
         ratio_a = (s3_numa_ff >= 0) && (s3_numa_ff <= s3_den_ff);
         ratio_b = (s3_numb_ff >= 0) && (s3_numb_ff <= s3_den_ff);
      end else begin
         ratio_a = (s3_numa_ff <= 0) && (s3_numa_ff >= s3_den_ff);
         ratio_b = (s3_numb_ff <= 0) && (s3_numb_ff >= s3_den_ff);
      end
      hit      = (s3_den_ff != 0) && ratio_a && ratio_b;
      numa_abs = s3_numa_ff[SUM_W-1] ? -s3_numa_ff : s3_numa_ff;
      den_abs  = s3_den_ff[SUM_W-1] ? -s3_den_ff : s3_den_ff;

      work_in.carry.valid = s3_valid_ff;
      work_in.carry.hit   = hit;
      work_in.carry.sxa   = s3_sxa_ff;
      work_in.carry.sya   = s3_sya_ff;
      work_in.carry.dxa   = s3_dxa_ff;
      work_in.carry.dya   = s3_dya_ff;
      work_in.num_mag     = numa_abs[MAG_W-1:0];
      work_in.den_mag     = den_abs[MAG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_ff.carry.valid <= 1'b0;
      end else if (en) begin
         work_ff <= work_in;
      end
   end

   assign work_out = work_ff;

endmodule

### design/sint_div.sv
module sint_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  sint_pkg::sint_work_type  work_in,
   output sint_pkg::sint_param_type param_out
);
   import sint_pkg::*;

   typedef struct packed {
      sint_carry_type     carry;
      logic [REM_W-1:0]   rem;
      logic [MAG_W-1:0]   den;
      logic [QUO_W-1:0]   quo;
   } sint_step_type;

   sint_step_type src [DIV_STAGES];
   sint_step_type st_in [DIV_STAGES];
   sint_step_type st_ff [DIV_STAGES];

   // Feed each stage from the one before it
   genvar g;
   generate
      for (g = 0; g < DIV_STAGES; g++) begin : g_src
         if (g == 0) begin : g_first
            always_comb begin
               src[g].carry = work_in.carry;
               src[g].rem   = {1'b0, work_in.num_mag};
               src[g].den   = work_in.den_mag;
               src[g].quo   = '0;
            end
         end else begin : g_next
            assign src[g] = st_ff[g-1];
         end
      end
   endgenerate

   // One restoring step per stage: the first stage takes the integer bit
   always_comb begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         logic [REM_W-1:0] shifted;
         logic             ge;
         shifted      = (k == 0) ? src[k].rem : {src[k].rem[REM_W-2:0], 1'b0};
         ge           = shifted >= {1'b0, src[k].den};
         st_in[k]     = src[k];
         st_in[k].rem = ge ? shifted - {1'b0, src[k].den} : shifted;
         st_in[k].quo = {src[k].quo[QUO_W-2:0], ge};
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (reset) begin
            st_ff[k].carry.valid <= 1'b0;
         end else if (en) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign param_out.carry = st_ff[DIV_STAGES-1].carry;
   assign param_out.quo   = st_ff[DIV_STAGES-1].quo;

endmodule

### design/sint_point.sv
module sint_point (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  sint_pkg::sint_param_type  param_in,
   output sint_pkg::sint_result_type result_out
);
   import sint_pkg::*;

   // Stage 1: scale the direction by t
   logic                         p1_valid_ff, p1_hit_ff;
   logic signed [COORD_BITS-1:0] p1_sxa_ff, p1_sya_ff;
   logic [QUO_W-1:0]             p1_quo_ff;
   logic signed [SCALE_W-1:0]    p1_px_ff, p1_py_ff;
   logic signed [QUO_W:0]        quo_s;

   assign quo_s = {1'b0, param_in.quo};

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= param_in.carry.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_hit_ff <= param_in.carry.hit;
         p1_sxa_ff <= param_in.carry.sxa;
         p1_sya_ff <= param_in.carry.sya;
         p1_quo_ff <= param_in.quo;
         p1_px_ff  <= SCALE_W'(param_in.carry.dxa) * SCALE_W'(quo_s);
         p1_py_ff  <= SCALE_W'(param_in.carry.dya) * SCALE_W'(quo_s);
      end
   end

   // Stage 2: add the start point, zero the fields on a miss
   logic signed [SCALE_W-1:0] sum_x, sum_y;
   sint_result_type           res_in, res_ff;

   always_comb begin
      sum_x = (SCALE_W'(p1_sxa_ff) <<< FRAC_BITS) + p1_px_ff;
      sum_y = (SCALE_W'(p1_sya_ff) <<< FRAC_BITS) + p1_py_ff;
      res_in.valid   = p1_valid_ff;
      res_in.hit     = p1_hit_ff;
      res_in.param   = p1_hit_ff ? p1_quo_ff : '0;
      res_in.cross_x = p1_hit_ff ? sum_x[CROSS_W-1:0] : '0;
      res_in.cross_y = p1_hit_ff ? sum_y[CROSS_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (en) begin
         res_ff <= res_in;
      end
   end

   assign result_out = res_ff;

endmodule

### design/segment_intersection_unit.sv
// Segment intersection unit: tests two integer segments A and B for an exact
// parametric crossing (inclusive at the endpoints, parallel or degenerate pairs
// never hit) and returns t along A in Q1.16 plus the crossing point in Q16.16.
// One word is taken per clock unless a result is waiting. A request passes through
// 4 front stages (differences, products, determinant, bounds test), 17
// divider stages that each resolve one bit of t, 2 point stages and the
// output register. The whole pipeline freezes while a result waits on
// rsp_tready, so throughput follows the downstream acceptance rate.
module segment_intersection_unit (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata from bit 0: a_start_x, a_start_y, a_end_x, a_end_y,
   //                       b_start_x, b_start_y, b_end_x, b_end_y
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sint_pkg::REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata from bit 0: param_a, cross_x, cross_y, zero pad
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sint_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: hit
   output logic                             rsp_tuser
);
   import sint_pkg::*;

   logic            en;
   sint_work_type   work;
   sint_param_type  param;
   sint_result_type result;

   // Output register
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   // Advance whenever the output register is free or being drained
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   sint_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .work_out (work)
   );

   sint_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .work_in   (work),
      .param_out (param)
   );

   sint_point u_point (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .param_in   (param),
      .result_out (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff  <= result.hit;
         rsp_data_ff <= RSP_DATA_W'({result.cross_y, result.cross_x, result.param});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule

### dv/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import sint_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PAIRS = 1100;
   localparam int DRAIN_CYCLES = 40;

   // One segment pair, packed so that a_start_x lands in the lowest bits of the word
   typedef struct packed {
      logic signed [COORD_BITS-1:0] b_end_y;
      logic signed [COORD_BITS-1:0] b_end_x;
      logic signed [COORD_BITS-1:0] b_start_y;
      logic signed [COORD_BITS-1:0] b_start_x;
      logic signed [COORD_BITS-1:0] a_end_y;
      logic signed [COORD_BITS-1:0] a_end_x;
      logic signed [COORD_BITS-1:0] a_start_y;
      logic signed [COORD_BITS-1:0] a_start_x;
   } seg_pair_type;

   typedef struct packed {
      logic               hit;
      logic [QUO_W-1:0]   param_a;
      logic [CROSS_W-1:0] cross_x;
      logic [CROSS_W-1:0] cross_y;
   } crossing_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;

   seg_pair_type pair_q[$];
   crossing_type crossing_q[$];
   seg_pair_type cur_pair;
   int unsigned directed_count = 0;
   int unsigned random_count = 0;
   int unsigned rsp_seen = 0;
   int unsigned hits_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   int unsigned holds_done = 0;

   segment_intersection_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // num/den within [0,1], den nonzero
   function automatic bit in_unit(longint num, longint den);
      if (den > 0)
         return num >= 0 && num <= den;
      return num <= 0 && num >= den;
   endfunction

   // Exact crossing test and fixed-point parameter/point for one pair
   function automatic crossing_type predict_crossing(seg_pair_type p);
      longint sxa, sya, sxb, syb, dxa, dya, dxb, dyb;
      longint den, numa, numb, cx, cy;
      longint unsigned n, d, q, r;
      crossing_type res;
      sxa = p.a_start_x;
      sya = p.a_start_y;
      sxb = p.b_start_x;
      syb = p.b_start_y;
      dxa = longint'(p.a_end_x) - sxa;
      dya = longint'(p.a_end_y) - sya;
      dxb = longint'(p.b_end_x) - sxb;
      dyb = longint'(p.b_end_y) - syb;
      den = dya * dxb - dxa * dyb;
      numa = (sxa - sxb) * dyb + (syb - sya) * dxb;
      numb = (sxa - sxb) * dya + (syb - sya) * dxa;
      res = '0;
      if (den == 0 || !in_unit(numa, den) || !in_unit(numb, den))
         return res;
      n = (numa < 0) ? longint'(-numa) : longint'(numa);
      d = (den < 0) ? longint'(-den) : longint'(den);
      // restoring division: integer bit first, then one fraction bit per step
      q = 0;
      r = n;
      if (r >= d) begin
         q = 1;
         r = r - d;
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 1;
         end
      end
      cx = (sxa << FRAC_BITS) + dxa * longint'(q);
      cy = (sya << FRAC_BITS) + dya * longint'(q);
      res.hit = 1'b1;
      res.param_a = q[QUO_W-1:0];
      res.cross_x = cx[CROSS_W-1:0];
      res.cross_y = cy[CROSS_W-1:0];
      return res;
   endfunction

   function automatic seg_pair_type mk(int ax0, int ay0, int ax1, int ay1,
                                       int bx0, int by0, int bx1, int by1);
      seg_pair_type p;
      p.a_start_x = ax0[COORD_BITS-1:0];
      p.a_start_y = ay0[COORD_BITS-1:0];
      p.a_end_x   = ax1[COORD_BITS-1:0];
      p.a_end_y   = ay1[COORD_BITS-1:0];
      p.b_start_x = bx0[COORD_BITS-1:0];
      p.b_start_y = by0[COORD_BITS-1:0];
      p.b_end_x   = bx1[COORD_BITS-1:0];
      p.b_end_y   = by1[COORD_BITS-1:0];
      return p;
   endfunction

   // Uniform coordinate in [-span, span-1]
   function automatic int rand_coord(int unsigned span);
      return int'($urandom_range(0, 2 * span - 1)) - int'(span);
   endfunction

   function automatic seg_pair_type rand_pair(int unsigned span);
      return mk(rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span),
                rand_coord(span), rand_coord(span), rand_coord(span), rand_coord(span));
   endfunction

   // Append one pair to the stimulus queue
   task automatic queue_pair(seg_pair_type p);
      pair_q = {pair_q, p};
   endtask

   task automatic report_mismatch(string field, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch on %s (result %0d): expected %0d, got %0d",
                  $realtime, field, rsp_seen, want, got);
   endtask

   // Stimulus and end of run
   initial begin : main_proc
      seg_pair_type p;
      int ax, ay, bx, by, dx, dy, k, mx, my;
      // crossings, fractions, parallel and collinear, endpoint touches, misses
      queue_pair(mk(0, 0, 10, 10, 0, 10, 10, 0));
      queue_pair(mk(0, 0, 3, 0, 1, -1, 1, 1));
      queue_pair(mk(0, 0, 7, 3, 2, 5, 4, -6));
      queue_pair(mk(0, 0, 10, 0, 0, 5, 10, 5));
      queue_pair(mk(0, 0, 10, 0, 5, 0, 15, 0));
      queue_pair(mk(0, 0, 10, 0, 0, -5, 0, 5));
      queue_pair(mk(0, 0, 10, 0, 10, -5, 10, 5));
      queue_pair(mk(0, 0, 10, 0, 5, 0, 5, 10));
      queue_pair(mk(0, 0, 10, 0, 5, 10, 5, 0));
      queue_pair(mk(0, 0, 10, 0, 10, 0, 20, 7));
      queue_pair(mk(3, 3, 3, 3, 0, 0, 6, 6));
      queue_pair(mk(1, 1, 1, 1, 1, 1, 1, 1));
      queue_pair(mk(0, 0, 1, 1, 5, 0, 0, 5));
      queue_pair(mk(0, 0, 10, 0, 5, 1, 5, 10));
      queue_pair(mk(0, 0, 10, 0, 5, 10, 5, 1));
      queue_pair(mk(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      queue_pair(mk(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767));
      queue_pair(mk(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
      queue_pair(mk(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
      queue_pair(mk(-32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767));
      queue_pair(mk(-1, -1, -1, -1, -1, -1, -1, -1));
      queue_pair(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      queue_pair(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
      directed_count = pair_q.size();

      // random pairs: mostly shapes that reach the divider, some noise
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: p = rand_pair(64);
            3:       p = rand_pair(2048);
            4, 5:    p = rand_pair(32768);
            6: begin
               // B starts or ends at a point whose x and y each come from an endpoint of A
               p = rand_pair(4096);
               if ($urandom_range(0, 1)) begin
                  p.b_start_x = $urandom_range(0, 1) ? p.a_start_x : p.a_end_x;
                  p.b_start_y = $urandom_range(0, 1) ? p.a_start_y : p.a_end_y;
               end else begin
                  p.b_end_x = $urandom_range(0, 1) ? p.a_start_x : p.a_end_x;
                  p.b_end_y = $urandom_range(0, 1) ? p.a_start_y : p.a_end_y;
               end
            end
            7: begin
               // B parallel to A, shifted or on the same line
               ax = rand_coord(8192);
               ay = rand_coord(8192);
               dx = rand_coord(512);
               dy = rand_coord(512);
               k = $urandom_range(1, 4);
               if ($urandom_range(0, 1)) begin
                  bx = ax + dx * int'($urandom_range(0, 3)) - dx;
                  by = ay + dy * int'($urandom_range(0, 3)) - dy;
               end else begin
                  bx = rand_coord(8192);
                  by = rand_coord(8192);
               end
               p = mk(ax, ay, ax + dx * k, ay + dy * k, bx, by, bx - dx, by - dy);
            end
            8: begin
               // B through the rounded midpoint of A, with a random direction and length
               ax = rand_coord(16384);
               ay = rand_coord(16384);
               bx = rand_coord(16384);
               by = rand_coord(16384);
               mx = (ax + bx) / 2;
               my = (ay + by) / 2;
               dx = rand_coord(16384);
               dy = rand_coord(16384);
               p = mk(ax, ay, bx, by, mx - dx, my - dy, mx + dx, my + dy);
            end
            default: begin
               // degenerate A or B, or one coordinate of each pinned to the range limits
               p = rand_pair(32768);
               case ($urandom_range(0, 2))
                  0: begin
                     p.a_end_x = p.a_start_x;
                     p.a_end_y = p.a_start_y;
                  end
                  1: begin
                     p.b_end_x = p.b_start_x;
                     p.b_end_y = p.b_start_y;
                  end
                  default: begin
                     p.a_start_x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                     p.b_end_y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                  end
               endcase
            end
         endcase
         queue_pair(p);
      end
      random_count = RANDOM_PAIRS;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // wait for the last word to go in and the last result to come out
      while (pair_q.size() != 0 || req_tvalid)
         @(posedge clock);
      while (crossing_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d segment pairs (%0d directed, %0d random): %0d hits, %0d misses",
               rsp_seen, directed_count, random_count, hits_seen, rsp_seen - hits_seen);
      $display("Receiver held off %0d times for %0d cycles with the pipeline full",
               holds_done, HOLD_CYCLES);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Sender: bursts of words with random gaps between them
   always @(posedge clock) begin : drive_proc
      int unsigned burst_left;
      int unsigned gap_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 48);
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            crossing_q = {crossing_q, predict_crossing(cur_pair)};
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pair_q.size() != 0) begin
               cur_pair = pair_q.pop_front();
               req_tdata <= cur_pair;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long hold-offs: stop draining twice so the pipeline fills and backs up
   always @(posedge clock) begin : holdoff_proc
      if (reset) begin
         hold_left <= 0;
         holds_done <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (holds_done < 2 && rsp_seen >= ((holds_done == 0) ? 150 : 650)) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
      end
   end

   // Receiver: cycle through always ready, random, sparse and periodic stalls
   always @(posedge clock) begin : sink_proc
      logic [9:0] phase;
      logic       take;
      if (reset) begin
         rsp_tready <= 1'b0;
         phase = '0;
      end else begin
         phase = phase + 1;
         case (phase[8:7])
            2'd0:    take = 1'b1;
            2'd1:    take = ($urandom_range(0, 1) == 1);
            2'd2:    take = ($urandom_range(0, 3) == 0);
            default: take = (phase[1:0] != 2'd0);
         endcase
         rsp_tready <= take && (hold_left == 0);
      end
   end

   // Compare each result word against the oldest prediction
   always @(posedge clock) begin : check_proc
      crossing_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (crossing_q.size() == 0) begin
            report_mismatch("unexpected result", 0, 1);
         end else begin
            want = crossing_q.pop_front();
            if (rsp_tuser !== want.hit)
               report_mismatch("hit", want.hit, rsp_tuser);
            if (rsp_tdata[QUO_W-1:0] !== want.param_a)
               report_mismatch("param_a", want.param_a, rsp_tdata[QUO_W-1:0]);
            if (rsp_tdata[QUO_W +: CROSS_W] !== want.cross_x)
               report_mismatch("cross_x", $signed(want.cross_x),
                               $signed(rsp_tdata[QUO_W +: CROSS_W]));
            if (rsp_tdata[QUO_W+CROSS_W +: CROSS_W] !== want.cross_y)
               report_mismatch("cross_y", $signed(want.cross_y),
                               $signed(rsp_tdata[QUO_W+CROSS_W +: CROSS_W]));
         end
         if (rsp_tuser === 1'b1)
            hits_seen <= hits_seen + 1;
         rsp_seen <= rsp_seen + 1;
      end
   end

   // Watchdog
   always @(posedge clock) begin : watchdog_proc
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, crossing_q.size());
         $display("FAILURE");
         $finish;
      end
   end

endmodule

### segment_intersection_unit.f
design/sint_pkg.sv
design/sint_front.sv
design/sint_div.sv
design/sint_point.sv
design/segment_intersection_unit.sv
dv/testbench.sv
